FILE: hdl/gsvc_pkg.sv
// Gear select valve controller: shared types and constants.
// Used by gear_select_valve_controller; depends on nothing.

package gsvc_pkg;

   localparam logic [5:0] GEAR_KICK    = 6'h30;
   localparam logic [3:0] SETTLE_RESET = 4'd3;

   localparam logic [1:0] LINE_CLASS_NEUTRAL = 2'd3;
   localparam logic [1:0] LINE_CLASS_REVERSE = 2'd2;

   localparam logic [1:0] GEAR_CLASS_FORWARD = 2'd0;
   localparam logic [1:0] GEAR_CLASS_REVERSE = 2'd1;
   localparam logic [1:0] GEAR_CLASS_NEUTRAL = 2'd2;
   localparam logic [1:0] GEAR_CLASS_KICK    = 2'd3;

   typedef struct packed {
      logic [5:0] line_levels;
      logic       brake_level;
   } gsvc_req_type;

   typedef struct packed {
      logic [4:0] valve_drive;
      logic       reverse_lamp;
      logic       neutral_interlock;
      logic [5:0] shown_gear;
      logic       gear_changed;
      logic       brake_changed;
      logic       kick_down_active;
   } gsvc_rsp_type;

endpackage

FILE: hdl/gear_select_valve_controller.sv
// Gear select valve controller top level: decode, debounce, kick-down toggle
// and valve selection. Depends on gsvc_pkg.
//
//  channel | ports                          | moves
//  --------+--------------------------------+-------------------------------
//  request | req_valid, req_stall, req_data | one scan per transaction
//  result  | rsp_valid, rsp_stall, rsp_data | one valve setting per scan
//  csr     | csr_wr_en, csr_wr_data         | settle_count, no read-back
//
// One transaction per cycle while the result is not stalled; a taken request
// passes through the input register, then the result register.
// All debounce and valve state updates when a scan moves into the result
// register. Reset is synchronous; settle_count returns to 3.
// A stalled result holds; the input register still takes one more scan.

module gear_select_valve_controller (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  gsvc_pkg::gsvc_req_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output gsvc_pkg::gsvc_rsp_type rsp_data,
   input  logic                  csr_wr_en,
   input  logic [3:0]            csr_wr_data
);
   import gsvc_pkg::*;

   logic         in_valid_ff;
   gsvc_req_type in_data_ff;
   logic         rsp_valid_ff;
   gsvc_rsp_type rsp_data_ff;
   logic         rsp_valid_in;
   gsvc_rsp_type rsp_data_in;

   logic [3:0] settle_ff;
   logic [5:0] stable_gear_ff, stable_gear_in;
   logic       stable_brake_ff, stable_brake_in;
   logic [3:0] gear_cnt_ff, gear_cnt_in;
   logic [3:0] brake_cnt_ff, brake_cnt_in;
   logic       kick_held_ff, kick_held_in;
   logic       kick_mode_ff, kick_mode_in;
   logic [6:0] valve_hold_ff, valve_hold_in;
   logic [5:0] display_gear_ff, display_gear_in;

   logic       rsp_load;
   logic       fire;
   logic       req_take;
   logic [5:0] gear_code;
   logic       gchg;
   logic       bchg;

   function automatic logic [5:0] decode_lines(input logic [5:0] lines);
      logic [5:0] step;
      step = 6'd0;
      case (lines[3:0])
         4'h4:    step = 6'd0;
         4'h0:    step = 6'd1;
         4'h2:    step = 6'd2;
         4'h6:    step = 6'd3;
         4'hE:    step = 6'd4;
         default: step = 6'd0;
      endcase
      if (lines[0]) begin
         return GEAR_KICK;
      end else if (lines[5:4] == LINE_CLASS_NEUTRAL) begin
         return step + 6'h20;
      end else if (lines[5:4] == LINE_CLASS_REVERSE) begin
         return step + 6'h10;
      end
      return step;
   endfunction

   function automatic logic [6:0] select_valves(input logic [5:0] gear, input logic brake,
                                                input logic kick, input logic [6:0] prev);
      logic [1:0] cls;
      logic [3:0] step;
      logic [4:0] valves;
      logic [6:0] lamps;
      cls    = gear[5:4];
      step   = gear[3:0];
      valves = prev[4:0];
      lamps  = 7'h00;
      if (cls == GEAR_CLASS_KICK) begin
         return prev;
      end
      if (cls == GEAR_CLASS_REVERSE) begin
         lamps = 7'h20;
      end else if (cls == GEAR_CLASS_NEUTRAL) begin
         lamps = 7'h40;
      end
      if (kick) begin
         if (cls == GEAR_CLASS_FORWARD) begin
            valves = brake ? 5'h0A : 5'h0E;
         end else if (cls == GEAR_CLASS_REVERSE) begin
            valves = brake ? 5'h0A : 5'h0F;
         end else begin
            valves = 5'h0A;
         end
      end else if (cls == GEAR_CLASS_FORWARD) begin
         case (step)
            4'd0:    valves = 5'h00;
            4'd1:    valves = brake ? 5'h0A : 5'h0E;
            4'd2:    valves = brake ? 5'h08 : 5'h0C;
            4'd3:    valves = 5'h04;
            4'd4:    valves = 5'h01;
            default: valves = prev[4:0];
         endcase
      end else if (cls == GEAR_CLASS_REVERSE) begin
         case (step)
            4'd0:    valves = 5'h00;
            4'd1:    valves = brake ? 5'h0A : 5'h0F;
            4'd2:    valves = brake ? 5'h08 : 5'h0D;
            4'd3:    valves = 5'h05;
            4'd4:    valves = 5'h05;
            default: valves = prev[4:0];
         endcase
      end else begin
         case (step)
            4'd0:    valves = 5'h00;
            4'd1:    valves = 5'h0A;
            4'd2:    valves = 5'h08;
            4'd3:    valves = 5'h00;
            4'd4:    valves = 5'h00;
            default: valves = prev[4:0];
         endcase
      end
      return lamps | {2'b00, valves};
   endfunction

   assign rsp_load  = !rsp_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && rsp_load;
   assign req_stall = in_valid_ff && !rsp_load;
   assign req_take  = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign gear_code = decode_lines(in_data_ff.line_levels);

   always_comb begin
      stable_gear_in  = stable_gear_ff;
      stable_brake_in = stable_brake_ff;
      gear_cnt_in     = gear_cnt_ff;
      brake_cnt_in    = brake_cnt_ff;
      kick_held_in    = kick_held_ff;
      kick_mode_in    = kick_mode_ff;
      display_gear_in = display_gear_ff;
      gchg            = 1'b0;
      bchg            = 1'b0;

      if (gear_code == GEAR_KICK) begin
         if (!kick_held_ff) begin
            kick_held_in    = 1'b1;
            gchg            = 1'b1;
            gear_cnt_in     = 4'd0;
            display_gear_in = GEAR_KICK;
            kick_mode_in    = !kick_mode_ff;
            if (kick_mode_ff) begin
               stable_gear_in = GEAR_KICK;
            end
         end
      end else begin
         kick_held_in = 1'b0;
         if (gear_code != stable_gear_ff) begin
            gear_cnt_in  = gear_cnt_ff + 4'd1;
            kick_mode_in = 1'b0;
            if (gear_cnt_in >= settle_ff) begin
               gchg            = 1'b1;
               gear_cnt_in     = 4'd0;
               stable_gear_in  = gear_code;
               display_gear_in = gear_code;
            end
         end
      end

      if (in_data_ff.brake_level != stable_brake_ff) begin
         brake_cnt_in = brake_cnt_ff + 4'd1;
         if (brake_cnt_in >= settle_ff) begin
            bchg            = 1'b1;
            brake_cnt_in    = 4'd0;
            stable_brake_in = in_data_ff.brake_level;
         end
      end

      valve_hold_in = select_valves(stable_gear_in, stable_brake_in, kick_mode_in,
                                    valve_hold_ff);

      rsp_data_in.valve_drive       = valve_hold_in[4:0];
      rsp_data_in.reverse_lamp      = valve_hold_in[5];
      rsp_data_in.neutral_interlock = valve_hold_in[6];
      rsp_data_in.shown_gear        = display_gear_in;
      rsp_data_in.gear_changed      = gchg;
      rsp_data_in.brake_changed     = bchg;
      rsp_data_in.kick_down_active  = kick_mode_in;

      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         settle_ff       <= SETTLE_RESET;
         stable_gear_ff  <= 6'd0;
         stable_brake_ff <= 1'b0;
         gear_cnt_ff     <= 4'd0;
         brake_cnt_ff    <= 4'd0;
         kick_held_ff    <= 1'b0;
         kick_mode_ff    <= 1'b0;
         valve_hold_ff   <= 7'd0;
         display_gear_ff <= 6'd0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_take) begin
            in_valid_ff <= 1'b1;
         end else if (fire) begin
            in_valid_ff <= 1'b0;
         end
         if (csr_wr_en) begin
            settle_ff <= csr_wr_data;
         end
         if (fire) begin
            stable_gear_ff  <= stable_gear_in;
            stable_brake_ff <= stable_brake_in;
            gear_cnt_ff     <= gear_cnt_in;
            brake_cnt_ff    <= brake_cnt_in;
            kick_held_ff    <= kick_held_in;
            kick_mode_ff    <= kick_mode_in;
            valve_hold_ff   <= valve_hold_in;
            display_gear_ff <= display_gear_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= req_data;
      end
      if (fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff)
      else $error("request stalled with empty input register");

   a_kick_matches_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_data_ff.kick_down_active == kick_mode_ff)
      else $error("kick-down flag out of step with mode register");

   a_gear_change_display: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.gear_changed |->
         rsp_data_ff.shown_gear == GEAR_KICK || rsp_data_ff.shown_gear == stable_gear_ff)
      else $error("gear change shows a code that is neither kick-down nor stable gear");

   a_brake_change_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.brake_changed |-> brake_cnt_ff == 4'd0)
      else $error("brake change accepted without clearing the mismatch count");
`endif

endmodule
